/* sv/mhpq_pkg.sv */
// Shared constants and types for the max-heap priority queue.
package mhpq_pkg;
   localparam int Capacity = 16;
   localparam int SlotW = $clog2(Capacity);
   localparam int CountW = $clog2(Capacity + 1);
   localparam int IdW = 16;
   localparam int KeyW = 31;
   localparam int CmdW = 3;
   localparam int StW = 2;

   localparam logic [CmdW-1:0] CMD_INSERT  = 3'd0;
   localparam logic [CmdW-1:0] CMD_EXTRACT = 3'd1;
   localparam logic [CmdW-1:0] CMD_UPDATE  = 3'd2;
   localparam logic [CmdW-1:0] CMD_REMOVE  = 3'd3;
   localparam logic [CmdW-1:0] CMD_PEEK    = 3'd4;

   localparam logic [StW-1:0] ST_OK       = 2'd0;
   localparam logic [StW-1:0] ST_FULL     = 2'd1;
   localparam logic [StW-1:0] ST_EMPTY    = 2'd2;
   localparam logic [StW-1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [IdW-1:0]  id;
      logic [KeyW-1:0] key;
   } entry_type;
endpackage

/* sv/max_heap_priority_queue.sv */
// Binary max-heap priority queue held in one synchronous slot memory.
// Peek reads the root; insert writes the new entry into the next free slot and sifts it up.
// Extract refills the root with the last entry and sinks it level by level; update and
// remove first search the slots in order for the id. One command at a time.
// The memory port allows one read and one write per cycle.
// Reset (synchronous, active high) empties the heap; slot contents stay undefined.
module max_heap_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // command[2:0], entry_id[18:3], key_value[49:19], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // status[1:0], result_id[17:2], result_key[48:18],
                                   // count_after[53:49], zero
);
   import mhpq_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_SRCH = 4'd2, S_SRCHW = 4'd3,
                          S_LAST = 4'd4, S_UPRD = 4'd5, S_UPCMP = 4'd6, S_DNRD = 4'd7,
                          S_DNL = 4'd8, S_DNR = 4'd9, S_DNCMP = 4'd10, S_OUT = 4'd11,
                          S_LASTW = 4'd12, S_UPRD2 = 4'd13;

   entry_type mem [Capacity];
   logic [SlotW-1:0] rd_addr, wr_addr;
   logic wr_en;
   entry_type wr_data, rd_q;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_q <= mem[rd_addr];
   end

   logic [3:0] state_ff, state_in;
   logic [CmdW-1:0] cmd_ff, cmd_in;
   logic [IdW-1:0] id_ff, id_in;
   logic [KeyW-1:0] key_ff, key_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [CountW-1:0] pos_ff, pos_in;   // current slot of the moving entry
   logic [CountW-1:0] oth_ff, oth_in;   // parent or best child slot
   entry_type cur_ff, cur_in;            // moving entry
   entry_type oth_e_ff, oth_e_in;
   logic moved_ff, moved_in;             // entry moved up; skip the down pass
   logic [StW-1:0] st_ff, st_in;
   logic [IdW-1:0] rid_ff, rid_in;
   logic [KeyW-1:0] rkey_ff, rkey_in;

   logic [CountW:0] lchild;
   assign lchild = {pos_ff, 1'b1};

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; id_in = id_ff; key_in = key_ff;
      cnt_in = cnt_ff; pos_in = pos_ff; oth_in = oth_ff; cur_in = cur_ff;
      oth_e_in = oth_e_ff; moved_in = moved_ff; st_in = st_ff;
      rid_in = rid_ff; rkey_in = rkey_ff;
      rd_addr = pos_ff[SlotW-1:0]; wr_en = 1'b0;
      wr_addr = pos_ff[SlotW-1:0]; wr_data = cur_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tdata[2:0]; id_in = req_tdata[18:3]; key_in = req_tdata[49:19];
               st_in = ST_OK; rid_in = '0; rkey_in = '0; pos_in = '0; moved_in = 1'b0;
               state_in = S_OUT;
               case (req_tdata[2:0]) inside
                  CMD_INSERT: begin
                     if (cnt_ff == CountW'(Capacity)) st_in = ST_FULL;
                     else begin
                        cur_in = '{id: req_tdata[18:3], key: req_tdata[49:19]};
                        pos_in = cnt_ff; cnt_in = cnt_ff + 1'b1;
                        wr_en = 1'b1; wr_addr = cnt_ff[SlotW-1:0];
                        wr_data = '{id: req_tdata[18:3], key: req_tdata[49:19]};
                        state_in = S_UPRD;
                     end
                  end
                  CMD_EXTRACT, CMD_PEEK: begin
                     if (cnt_ff == '0) st_in = ST_EMPTY;
                     else state_in = S_RD0;
                  end
                  CMD_UPDATE, CMD_REMOVE: begin
                     if (cnt_ff == '0) st_in = ST_NOTFOUND;
                     else state_in = S_SRCH;
                  end
                  default: ;
               endcase
            end
         end
         S_RD0: begin
            rd_addr = '0; state_in = S_SRCHW; pos_in = '0;
         end
         S_SRCH: begin
            rd_addr = pos_ff[SlotW-1:0]; state_in = S_SRCHW;
         end
         S_SRCHW: begin
            if (cmd_ff == CMD_EXTRACT || cmd_ff == CMD_PEEK) begin
               rid_in = rd_q.id; rkey_in = rd_q.key;
               if (cmd_ff == CMD_PEEK) state_in = S_OUT;
               else state_in = S_LAST;
            end else if (rd_q.id == id_ff) begin
               if (cmd_ff == CMD_UPDATE) begin
                  cur_in = '{id: rd_q.id, key: key_ff};
                  wr_en = 1'b1; wr_data = '{id: rd_q.id, key: key_ff};
                  state_in = S_UPRD;
               end else state_in = S_LAST;
            end else if (pos_ff + 1'b1 == cnt_ff) begin
               st_in = ST_NOTFOUND; state_in = S_OUT;
            end else begin
               pos_in = pos_ff + 1'b1; state_in = S_SRCH;
            end
         end
         S_LAST: begin
            // drop the last entry, then fill the hole with it
            cnt_in = cnt_ff - 1'b1;
            rd_addr = SlotW'(cnt_ff - 1'b1);
            if (pos_ff == cnt_ff - 1'b1) state_in = S_OUT;
            else state_in = S_LASTW;
         end
         S_LASTW: begin
            cur_in = rd_q; wr_en = 1'b1; wr_data = rd_q; state_in = S_UPRD;
         end
         S_UPRD: begin
            if (pos_ff == '0) state_in = S_DNRD;
            else begin
               oth_in = (pos_ff - 1'b1) >> 1;
               state_in = S_UPRD2;
            end
         end
         S_UPRD2: begin
            rd_addr = oth_ff[SlotW-1:0]; state_in = S_UPCMP;
         end
         S_UPCMP: begin
            if (cur_ff.key > rd_q.key) begin
               wr_en = 1'b1; wr_addr = pos_ff[SlotW-1:0]; wr_data = rd_q;
               pos_in = oth_ff; moved_in = 1'b1; state_in = S_UPRD;
            end else state_in = S_DNRD;
            if (cur_ff.key > rd_q.key && oth_ff == '0) state_in = S_DNRD;
         end
         S_DNRD: begin
            // write the entry at its current slot; go down only if it never rose
            wr_en = 1'b1;
            oth_in = pos_ff; oth_e_in = cur_ff;
            if (moved_ff || lchild >= {1'b0, cnt_ff}) state_in = S_OUT;
            else begin
               rd_addr = SlotW'(lchild); state_in = S_DNL;
            end
         end
         S_DNL: begin
            if (rd_q.key > oth_e_ff.key) begin
               oth_in = lchild[CountW-1:0]; oth_e_in = rd_q;
            end
            if (lchild + 1'b1 < {1'b0, cnt_ff}) begin
               rd_addr = SlotW'(lchild + 1'b1); state_in = S_DNR;
            end else state_in = S_DNCMP;
         end
         S_DNR: begin
            if (rd_q.key > oth_e_ff.key) begin
               oth_in = CountW'(lchild + 1'b1); oth_e_in = rd_q;
            end
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (oth_ff == pos_ff) state_in = S_OUT;
            else begin
               wr_en = 1'b1; wr_data = oth_e_ff;
               pos_in = oth_ff; state_in = S_DNRD;
            end
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in;
      end
      cmd_ff <= cmd_in; id_ff <= id_in; key_ff <= key_in; pos_ff <= pos_in;
      oth_ff <= oth_in; cur_ff <= cur_in; oth_e_ff <= oth_e_in; moved_ff <= moved_in;
      st_ff <= st_in; rid_ff <= rid_in; rkey_ff <= rkey_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {2'b0, cnt_ff, rkey_ff, rid_ff, st_ff};
endmodule

/* sv/mhpq_checker.sv */
// Port-level checker for the max-heap priority queue.
module mhpq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [55:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("req ready while word pending");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[53:49] <= 5'd16) else $error("count too large");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == 2'd2) |-> rsp_tdata[48:2] == '0)
      else $error("empty result not zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("word dropped");
endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);
